### design/lbgt_pkg.sv
package lbgt_pkg;

  localparam int X_W        = 10;
  localparam int Y_W        = 7;
  localparam int DIST_W     = 10;
  localparam int MB_W       = 7;
  localparam int ACT_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  // distance to a saturated center stays below 2^(X_W+1)
  localparam int ROOT_W = X_W + 1;
  localparam int SQ_W   = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;
  localparam int ITER   = ROOT_W;
  localparam int CNT_W  = $clog2(ITER + 1);

  localparam logic [X_W-1:0]    X_MAX   = '1;
  localparam logic [Y_W-1:0]    Y_MAX   = '1;
  localparam logic [DIST_W-1:0] NO_BEST = '1;

  localparam logic [X_W-1:0]    LEFT_START_X     = X_W'(160);
  localparam logic [X_W-1:0]    RIGHT_START_X    = X_W'(480);
  localparam logic [Y_W-1:0]    START_Y          = Y_W'(45);
  localparam logic [MB_W-1:0]   MIN_BOTTOM_RST   = MB_W'(60);
  localparam logic [DIST_W-1:0] MAX_DISTANCE_RST = DIST_W'(120);

  typedef enum logic [ACT_W-1:0] {
    ACT_BOX     = 2'd0,
    ACT_BOX_EOF = 2'd1,
    ACT_EOF     = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_BOTTOM   = 1'b0,
    REG_MAX_DISTANCE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic load;
    logic center;
    logic square;
    logic start;
    logic update;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_box;
    logic is_eof;
    logic sqrt_done;
    logic out_busy;
  } dp_status_t;

endpackage

### design/lbgt_isqrt.sv
module lbgt_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lbgt_pkg::SQ_W-1:0]  radicand_i,
  output logic                       done_o,
  output logic [lbgt_pkg::ROOT_W-1:0] root_o
);
  import lbgt_pkg::*;

  logic                run_q, run_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SQ_W-1:0]     rad_q, rad_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    trial;

  assign rem_sh = {rem_q[REM_W-3:0], rad_q[SQ_W-1 -: 2]};
  assign trial  = REM_W'({root_q, 2'b01});

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = CNT_W'(ITER);
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (run_q) begin
      rad_d = {rad_q[SQ_W-3:0], 2'b00};
      cnt_d = cnt_q - 1'b1;
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### design/lbgt_datapath.sv
module lbgt_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lbgt_pkg::ctrl_cmd_t            cmd_i,
  output lbgt_pkg::dp_status_t           status_o,
  input  logic                           cfg_we_i,
  input  logic [lbgt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lbgt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [lbgt_pkg::ACT_W-1:0]     action_i,
  input  logic [lbgt_pkg::X_W-1:0]       box_left_i,
  input  logic [lbgt_pkg::Y_W-1:0]       box_top_i,
  input  logic [lbgt_pkg::X_W-1:0]       box_width_i,
  input  logic [lbgt_pkg::Y_W-1:0]       box_height_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [lbgt_pkg::X_W-1:0]       error_x_o
);
  import lbgt_pkg::*;

  function automatic logic [X_W-1:0] abs_diff(logic [X_W-1:0] a, logic [X_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  logic [MB_W-1:0]   min_bottom_q;
  logic [DIST_W-1:0] max_distance_q;

  logic [ACT_W-1:0] act_q;
  logic [X_W-1:0]   left_q, width_q;
  logic [Y_W-1:0]   top_q, height_q;

  logic [X_W-1:0]    cx_q, lx_q, rx_q;
  logic [Y_W-1:0]    cy_q, ly_q, ry_q;
  logic              low_q;
  logic [DIST_W-1:0] best_l_q, best_r_q;
  logic [SQ_W-1:0]   sq_l_q, sq_r_q;
  logic              out_valid_q, out_valid_d;
  logic [X_W-1:0]    error_x_q;

  // center with round half to even, then saturation
  logic [X_W+1:0] sum_x;
  logic [Y_W+1:0] sum_y;
  logic [X_W:0]   half_x;
  logic [Y_W:0]   half_y;
  logic [X_W-1:0] cx;
  logic [Y_W-1:0] cy;
  logic [Y_W:0]   bottom;

  assign sum_x  = {1'b0, left_q, 1'b0} + (X_W+2)'(width_q);
  assign sum_y  = {1'b0, top_q, 1'b0} + (Y_W+2)'(height_q);
  assign half_x = sum_x[X_W+1:1] + (X_W+1)'(sum_x[0] & sum_x[1]);
  assign half_y = sum_y[Y_W+1:1] + (Y_W+1)'(sum_y[0] & sum_y[1]);
  assign cx     = half_x[X_W] ? X_MAX : half_x[X_W-1:0];
  assign cy     = half_y[Y_W] ? Y_MAX : half_y[Y_W-1:0];
  assign bottom = (Y_W+1)'(top_q) + (Y_W+1)'(height_q);

  // squared distances
  logic [X_W-1:0]   dx_l, dx_r;
  logic [Y_W-1:0]   dy_l, dy_r;
  logic [2*X_W-1:0] dxx_l, dxx_r;
  logic [2*Y_W-1:0] dyy_l, dyy_r;

  assign dx_l  = abs_diff(cx_q, lx_q);
  assign dx_r  = abs_diff(cx_q, rx_q);
  assign dy_l  = Y_W'(abs_diff(X_W'(cy_q), X_W'(ly_q)));
  assign dy_r  = Y_W'(abs_diff(X_W'(cy_q), X_W'(ry_q)));
  assign dxx_l = dx_l * dx_l;
  assign dxx_r = dx_r * dx_r;
  assign dyy_l = dy_l * dy_l;
  assign dyy_r = dy_r * dy_r;

  logic              done_l, done_r;
  logic [ROOT_W-1:0] root_l, root_r;

  lbgt_isqrt u_isqrt_l (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start),
    .radicand_i (sq_l_q),
    .done_o     (done_l),
    .root_o     (root_l)
  );

  lbgt_isqrt u_isqrt_r (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start),
    .radicand_i (sq_r_q),
    .done_o     (done_r),
    .root_o     (root_r)
  );

  logic hit_l, hit_r;
  assign hit_l = low_q && (ROOT_W'(best_l_q) > root_l) && (root_l < ROOT_W'(max_distance_q));
  assign hit_r = low_q && (ROOT_W'(best_r_q) > root_r) && (root_r < ROOT_W'(max_distance_q));

  logic [X_W:0] mid_sum;
  assign mid_sum = (X_W+1)'(lx_q) + (X_W+1)'(rx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_bottom_q   <= MIN_BOTTOM_RST;
      max_distance_q <= MAX_DISTANCE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MIN_BOTTOM:   min_bottom_q   <= cfg_data_i[MB_W-1:0];
        REG_MAX_DISTANCE: max_distance_q <= cfg_data_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q        <= LEFT_START_X;
      ly_q        <= START_Y;
      rx_q        <= RIGHT_START_X;
      ry_q        <= START_Y;
      best_l_q    <= NO_BEST;
      best_r_q    <= NO_BEST;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.update && hit_l) begin
        lx_q     <= cx_q;
        ly_q     <= cy_q;
        best_l_q <= root_l[DIST_W-1:0];
      end
      if (cmd_i.update && hit_r) begin
        rx_q     <= cx_q;
        ry_q     <= cy_q;
        best_r_q <= root_r[DIST_W-1:0];
      end
      if (cmd_i.emit) begin
        best_l_q <= NO_BEST;
        best_r_q <= NO_BEST;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q    <= action_i;
      left_q   <= box_left_i;
      top_q    <= box_top_i;
      width_q  <= box_width_i;
      height_q <= box_height_i;
    end
    if (cmd_i.center) begin
      cx_q  <= cx;
      cy_q  <= cy;
      low_q <= bottom > (Y_W+1)'(min_bottom_q);
    end
    if (cmd_i.square) begin
      sq_l_q <= SQ_W'(dxx_l) + SQ_W'(dyy_l);
      sq_r_q <= SQ_W'(dxx_r) + SQ_W'(dyy_r);
    end
    if (cmd_i.emit) begin
      error_x_q <= mid_sum[X_W:1];
    end
  end

  assign status_o.is_box    = (act_q == ACT_BOX) || (act_q == ACT_BOX_EOF);
  assign status_o.is_eof    = (act_q != ACT_BOX);
  assign status_o.sqrt_done = done_l & done_r;
  assign status_o.out_busy  = out_valid_q & out_stall_i;

  assign out_valid_o = out_valid_q;
  assign error_x_o   = error_x_q;

  logic [SQ_W+1:0] root_lo_sq, root_hi_sq;
  assign root_lo_sq = (SQ_W+2)'(root_l) * (SQ_W+2)'(root_l);
  assign root_hi_sq = ((SQ_W+2)'(root_l) + 1'b1) * ((SQ_W+2)'(root_l) + 1'b1);

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !(out_valid_q && out_stall_i))
    else $error("frame result overwrote a pending transfer");

  a_best_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (best_l_q == NO_BEST) && (best_r_q == NO_BEST))
    else $error("best distances not cleared at frame end");

  a_root_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_l |-> (root_lo_sq <= (SQ_W+2)'(sq_l_q)) && (root_hi_sq > (SQ_W+2)'(sq_l_q)))
    else $error("square root result out of range");

endmodule

### design/lbgt_ctrl.sv
module lbgt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lbgt_pkg::dp_status_t status_i,
  output lbgt_pkg::ctrl_cmd_t  cmd_o
);
  import lbgt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CENTER = 7'b0000010,
    S_SQUARE = 7'b0000100,
    S_START  = 7'b0001000,
    S_ROOT   = 7'b0010000,
    S_UPDATE = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CENTER;
        end
      end
      S_CENTER: begin
        cmd_o.center = 1'b1;
        state_d      = status_i.is_box ? S_SQUARE : S_EMIT;
      end
      S_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = S_START;
      end
      S_START: begin
        cmd_o.start = 1'b1;
        state_d     = S_ROOT;
      end
      S_ROOT: begin
        if (status_i.sqrt_done) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = status_i.is_eof ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_root_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.sqrt_done |-> (state_q == S_ROOT))
    else $error("root finished outside of its wait state");

endmodule

### design/lane_blob_gated_tracker_unit.sv
// Tracks a left and a right lane point from the blob bounding boxes of each
// frame, one box per input transfer, and returns the floor midpoint x of the
// two points as one output transfer at every end of frame. A box item passes the
// center, square, start, root and update states before the next one is taken;
// the root state waits for the bit-serial integer square root, one root bit per
// cycle over 11 bits (both points run their own root unit in parallel). A box
// ending the frame adds the emit state; a lone frame end goes center then emit.
// The result sits in an output register, so new items are taken while it waits;
// a frame end only stalls when the previous result is still not transferred.
// Configuration writes are taken at any cycle and belong between items.
module lane_blob_gated_tracker_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lbgt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lbgt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [lbgt_pkg::ACT_W-1:0]      action_i,
  input  logic [lbgt_pkg::X_W-1:0]        box_left_i,
  input  logic [lbgt_pkg::Y_W-1:0]        box_top_i,
  input  logic [lbgt_pkg::X_W-1:0]        box_width_i,
  input  logic [lbgt_pkg::Y_W-1:0]        box_height_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lbgt_pkg::X_W-1:0]        error_x_o
);
  import lbgt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lbgt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lbgt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .action_i     (action_i),
    .box_left_i   (box_left_i),
    .box_top_i    (box_top_i),
    .box_width_i  (box_width_i),
    .box_height_i (box_height_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .error_x_o    (error_x_o)
  );

endmodule

### test/lane_blob_gated_tracker_unit_tb.sv
`timescale 1ns / 1ps

module lane_blob_gated_tracker_unit_tb;
  import lbgt_pkg::*;

  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int BLOCK_ITEMS    = 142;
  localparam int NUM_BLOCKS     = 4;
  // spare action code, also ends the frame
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [X_W-1:0]   box_left;
    logic [Y_W-1:0]   box_top;
    logic [X_W-1:0]   box_width;
    logic [Y_W-1:0]   box_height;
  } box_item_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [X_W-1:0]   box_left;
    logic [Y_W-1:0]   box_top;
    logic [X_W-1:0]   box_width;
    logic [Y_W-1:0]   box_height;
    logic             typed;
    logic [X_W-1:0]   mid_x;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS[14] = '{
    '{ACT_EOF,     10'd0,    7'd0,   10'd0,    7'd0,   1'b1, 10'd320},
    '{ACT_SPARE,   10'd0,    7'd0,   10'd0,    7'd0,   1'b1, 10'd320},
    '{ACT_BOX_EOF, 10'd0,    7'd0,   10'd0,    7'd0,   1'b1, 10'd320},
    '{ACT_BOX_EOF, 10'd1023, 7'd127, 10'd1023, 7'd127, 1'b1, 10'd320},
    '{ACT_BOX,     10'd150,  7'd30,  10'd20,   7'd30,  1'b0, 10'd0},
    '{ACT_BOX,     10'd150,  7'd31,  10'd20,   7'd30,  1'b0, 10'd0},
    '{ACT_BOX_EOF, 10'd150,  7'd40,  10'd20,   7'd30,  1'b0, 10'd0},
    '{ACT_BOX,     10'd100,  7'd40,  10'd41,   7'd30,  1'b0, 10'd0},
    '{ACT_BOX_EOF, 10'd100,  7'd40,  10'd43,   7'd30,  1'b0, 10'd0},
    '{ACT_BOX,     10'd2,    7'd40,  10'd0,    7'd30,  1'b0, 10'd0},
    '{ACT_BOX,     10'd3,    7'd40,  10'd0,    7'd30,  1'b0, 10'd0},
    '{ACT_BOX,     10'd470,  7'd40,  10'd21,   7'd30,  1'b0, 10'd0},
    '{ACT_BOX_EOF, 10'd639,  7'd89,  10'd640,  7'd90,  1'b0, 10'd0},
    '{ACT_EOF,     10'd0,    7'd0,   10'd0,    7'd0,   1'b0, 10'd0}
  };

  localparam int MB_SETTINGS[NUM_BLOCKS*3] = '{60, 0, 90, 127, 30, 60, 45, 0, 90, 75, 60, 20};
  localparam int MD_SETTINGS[NUM_BLOCKS*3] = '{120, 1023, 0, 500, 60, 200, 1, 1023, 120, 300,
                                              80, 1000};
  localparam int SEND_IDLE[3]  = '{33, 51, 0};
  localparam int STALL_IDLE[3] = '{51, 33, 0};

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [ACT_W-1:0]      action_i     = '0;
  logic [X_W-1:0]        box_left_i   = '0;
  logic [Y_W-1:0]        box_top_i    = '0;
  logic [X_W-1:0]        box_width_i  = '0;
  logic [Y_W-1:0]        box_height_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic [X_W-1:0]        error_x_o;

  // tracker state kept by the testbench, index 0 left and 1 right
  int track_x[2];
  int track_y[2];
  int best_dist[2];
  int min_bottom_reg;
  int max_distance_reg;

  logic [X_W-1:0] expected_mid_x[$];
  logic [X_W-1:0] oldest_mid_x;
  int             fail_count = 0;
  int             send_pct   = 0;
  int             stall_pct  = 0;
  int             idle_cycles;

  lane_blob_gated_tracker_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .box_left_i   (box_left_i),
    .box_top_i    (box_top_i),
    .box_width_i  (box_width_i),
    .box_height_i (box_height_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .error_x_o    (error_x_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int floor_root(int n);
    longint r;
    longint trial;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = r | (longint'(1) << b);
      if (trial * trial <= longint'(n)) r = trial;
    end
    return int'(r);
  endfunction

  function automatic int halve_to_even(int twice);
    int h;
    h = twice >> 1;
    if ((twice & 1) != 0 && (h & 1) != 0) h = h + 1;
    return h;
  endfunction

  task automatic reset_tracker();
    track_x[0]       = int'(LEFT_START_X);
    track_x[1]       = int'(RIGHT_START_X);
    track_y[0]       = int'(START_Y);
    track_y[1]       = int'(START_Y);
    best_dist[0]     = int'(NO_BEST);
    best_dist[1]     = int'(NO_BEST);
    min_bottom_reg   = int'(MIN_BOTTOM_RST);
    max_distance_reg = int'(MAX_DISTANCE_RST);
  endtask

  task automatic track_box(input box_item_t it, output bit emits,
                           output logic [X_W-1:0] mid_x);
    int  cx;
    int  cy;
    int  dx;
    int  dy;
    int  root;
    bit  low_enough;
    emits = 1'b0;
    mid_x = '0;
    if (it.action == ACT_BOX || it.action == ACT_BOX_EOF) begin
      cx = halve_to_even(2 * int'(it.box_left) + int'(it.box_width));
      cy = halve_to_even(2 * int'(it.box_top) + int'(it.box_height));
      low_enough = (int'(it.box_top) + int'(it.box_height)) > min_bottom_reg;
      if (cx > int'(X_MAX)) cx = int'(X_MAX);
      if (cy > int'(Y_MAX)) cy = int'(Y_MAX);
      for (int side = 0; side < 2; side++) begin
        dx = (cx > track_x[side]) ? cx - track_x[side] : track_x[side] - cx;
        dy = (cy > track_y[side]) ? cy - track_y[side] : track_y[side] - cy;
        root = floor_root(dx * dx + dy * dy);
        if (best_dist[side] > root && low_enough && root < max_distance_reg) begin
          track_x[side]   = cx;
          track_y[side]   = cy;
          best_dist[side] = root;
        end
      end
    end
    if (it.action != ACT_BOX) begin
      emits        = 1'b1;
      mid_x        = X_W'((track_x[0] + track_x[1]) >> 1);
      best_dist[0] = int'(NO_BEST);
      best_dist[1] = int'(NO_BEST);
    end
  endtask

  function automatic box_item_t random_box();
    box_item_t it;
    int        sel;
    int        side;
    int        span;
    int        w;
    int        h;
    int        lft;
    int        tp;
    sel = $urandom_range(99);
    it.action = ACT_BOX;
    if (sel < 15) begin
      it.box_left   = X_W'($urandom_range(1023));
      it.box_top    = Y_W'($urandom_range(127));
      it.box_width  = X_W'($urandom_range(1023));
      it.box_height = Y_W'($urandom_range(127));
    end else if (sel < 40) begin
      it.box_left   = X_W'($urandom_range(639));
      it.box_top    = Y_W'($urandom_range(89));
      it.box_width  = X_W'($urandom_range(640));
      it.box_height = Y_W'($urandom_range(90));
    end else begin
      // box centered near one tracked point
      side = $urandom_range(1);
      span = (max_distance_reg >= 150) ? 150 : max_distance_reg + 2;
      w    = $urandom_range(60);
      h    = $urandom_range(60, 2);
      lft  = track_x[side] + int'($urandom_range(2 * span)) - span - w / 2;
      tp   = track_y[side] + int'($urandom_range(40)) - 20 - h / 2;
      if (lft < 0) lft = 0;
      if (lft > 1023) lft = 1023;
      if (tp < 0) tp = 0;
      if (tp > 127) tp = 127;
      it.box_left   = X_W'(lft);
      it.box_top    = Y_W'(tp);
      it.box_width  = X_W'(w);
      it.box_height = Y_W'(h);
    end
    return it;
  endfunction

  task automatic send_box(input box_item_t it, input bit typed,
                          input logic [X_W-1:0] typed_mid_x);
    bit             emits;
    logic [X_W-1:0] mid_x;
    while ($urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= it.action;
    box_left_i   <= it.box_left;
    box_top_i    <= it.box_top;
    box_width_i  <= it.box_width;
    box_height_i <= it.box_height;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_box(it, emits, mid_x);
    if (emits) expected_mid_x.push_back(typed ? typed_mid_x : mid_x);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_mid_x.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input int min_bottom, input int max_distance);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_MIN_BOTTOM;
    cfg_data_i  <= CFG_DATA_W'(min_bottom);
    @(posedge clk_i);
    cfg_index_i <= REG_MAX_DISTANCE;
    cfg_data_i  <= CFG_DATA_W'(max_distance);
    @(posedge clk_i);
    cfg_we_i         <= 1'b0;
    min_bottom_reg   = min_bottom & 'h7f;
    max_distance_reg = max_distance & 'h3ff;
  endtask

  task automatic run_frames(input int num_items);
    int        sent;
    int        nbox;
    bit        ended;
    box_item_t it;
    sent = 0;
    while (sent < num_items) begin
      nbox  = $urandom_range(4);
      ended = 1'b0;
      for (int i = 0; i < nbox; i++) begin
        it = random_box();
        if (i == nbox - 1 && $urandom_range(1) == 1) begin
          it.action = ACT_BOX_EOF;
          ended     = 1'b1;
        end
        send_box(it, 1'b0, '0);
        sent++;
      end
      if (!ended) begin
        it = random_box();
        if ($urandom_range(4) == 0) it.action = ACT_SPARE;
        else it.action = ACT_EOF;
        send_box(it, 1'b0, '0);
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_mid_x.size() == 0) begin
        $error("error_x: no transfer expected, actual %0d", error_x_o);
        fail_count++;
      end else begin
        oldest_mid_x = expected_mid_x.pop_front();
        if (error_x_o !== oldest_mid_x) begin
          $error("error_x: expected %0d, actual %0d", oldest_mid_x, error_x_o);
          fail_count++;
        end
      end
    end
  end

  // ends the run after too many cycles without any transfer
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    box_item_t it;
    reset_tracker();
    send_pct  = SEND_IDLE[0];
    stall_pct = STALL_IDLE[0];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      it.action     = DIRECTED_ROWS[i].action;
      it.box_left   = DIRECTED_ROWS[i].box_left;
      it.box_top    = DIRECTED_ROWS[i].box_top;
      it.box_width  = DIRECTED_ROWS[i].box_width;
      it.box_height = DIRECTED_ROWS[i].box_height;
      send_box(it, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].mid_x);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_pct  = SEND_IDLE[phase];
      stall_pct = STALL_IDLE[phase];
      for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
        drain_results();
        write_config(MB_SETTINGS[phase * NUM_BLOCKS + blk],
                     MD_SETTINGS[phase * NUM_BLOCKS + blk]);
        run_frames(BLOCK_ITEMS);
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
